/* hdl/satm_pkg.sv */
// Shared widths, types and helpers for the six-arm thrust mixer.
package satm_pkg;

  localparam int IN_W      = 24;
  localparam int FRAC_BITS = 8;
  localparam int PWM_W     = 16;
  localparam int COEF_W    = 15;
  localparam int COEF_FRAC = 14;
  localparam int MIN_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // signed product, three-term torque sum, arm sum, magnitude, whole counts
  localparam int PROD_W = IN_W + COEF_W + 1;
  localparam int TQ_W   = PROD_W + 2;
  localparam int ARM_W  = TQ_W + 1;
  localparam int MAG_W  = ARM_W - 1;
  localparam int CNT_W  = MAG_W - FRAC_BITS - COEF_FRAC;
  localparam int SUM_W  = ((CNT_W > MIN_W) ? CNT_W : MIN_W) + 1;

  localparam logic [MIN_W-1:0]  IDLE_CNT_RST   = MIN_W'(4000);
  localparam logic [COEF_W-1:0] COEF_SMALL_RST = COEF_W'(156);
  localparam logic [COEF_W-1:0] COEF_MID_RST   = COEF_W'(1642);
  localparam logic [COEF_W-1:0] COEF_LARGE_RST = COEF_W'(17231);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_CNT   = 2'd0,
    REG_COEF_SMALL = 2'd1,
    REG_COEF_MID   = 2'd2,
    REG_COEF_LARGE = 2'd3
  } satm_reg_t;

  // per-stage load enables, stage 5 first (most significant), stage 1 last
  typedef struct packed {
    logic ld5;
    logic ld4;
    logic ld3;
    logic ld2;
    logic ld1;
  } satm_adv_t;

  function automatic logic [PWM_W-1:0] sat_pwm(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] hi;
    hi = v >> PWM_W;
    if (hi != '0) begin
      sat_pwm = '1;
    end else begin
      sat_pwm = PWM_W'(v);
    end
  endfunction

endpackage

/* hdl/satm_if.sv */
// Valid/ready channel interfaces for mixer commands and motor PWM results.
interface satm_cmd_if
  import satm_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] force_x;
  logic signed [IN_W-1:0] force_y;
  logic signed [IN_W-1:0] force_z;
  logic signed [IN_W-1:0] torque_x;
  logic signed [IN_W-1:0] torque_y;
  logic signed [IN_W-1:0] torque_z;
  logic                   run_enable;

  modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  run_enable, input ready);
  modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  run_enable, output ready);
endinterface

interface satm_pwm_if
  import satm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PWM_W-1:0] arm1_up_pwm;
  logic [PWM_W-1:0] arm1_down_pwm;
  logic [PWM_W-1:0] arm2_up_pwm;
  logic [PWM_W-1:0] arm2_down_pwm;
  logic [PWM_W-1:0] arm3_up_pwm;
  logic [PWM_W-1:0] arm3_down_pwm;
  logic [PWM_W-1:0] arm4_up_pwm;
  logic [PWM_W-1:0] arm4_down_pwm;
  logic [PWM_W-1:0] arm5_up_pwm;
  logic [PWM_W-1:0] arm5_down_pwm;
  logic [PWM_W-1:0] arm6_up_pwm;
  logic [PWM_W-1:0] arm6_down_pwm;

  modport source (output valid, arm1_up_pwm, arm1_down_pwm, arm2_up_pwm, arm2_down_pwm,
                  arm3_up_pwm, arm3_down_pwm, arm4_up_pwm, arm4_down_pwm,
                  arm5_up_pwm, arm5_down_pwm, arm6_up_pwm, arm6_down_pwm, input ready);
  modport sink   (input valid, arm1_up_pwm, arm1_down_pwm, arm2_up_pwm, arm2_down_pwm,
                  arm3_up_pwm, arm3_down_pwm, arm4_up_pwm, arm4_down_pwm,
                  arm5_up_pwm, arm5_down_pwm, arm6_up_pwm, arm6_down_pwm, output ready);
endinterface

/* hdl/satm_pair.sv */
// Five-stage datapath for one mirrored arm pair: products, torque sum, arm sums, magnitudes, drive.
module satm_pair
  import satm_pkg::*;
(
  input  logic                   clk,
  input  satm_adv_t              adv,
  input  logic [COEF_W-1:0]      coef_tx,
  input  logic [COEF_W-1:0]      coef_ty,
  input  logic [COEF_W-1:0]      coef_tz,
  input  logic [2:0]             neg,      // subtract term: bit 0 tx, bit 1 ty, bit 2 tz
  input  logic [MIN_W-1:0]       idle_cnt,
  input  logic signed [IN_W-1:0] axis_force,
  input  logic signed [IN_W-1:0] tx,
  input  logic signed [IN_W-1:0] ty,
  input  logic signed [IN_W-1:0] tz,
  input  logic                   run,
  output logic [PWM_W-1:0]       pos_up,
  output logic [PWM_W-1:0]       pos_down,
  output logic [PWM_W-1:0]       neg_up,
  output logic [PWM_W-1:0]       neg_down
);

  localparam int SHIFT = FRAC_BITS + COEF_FRAC;

  // stage 1
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [IN_W-1:0]   f1_r;
  logic                     run1_r;
  // stage 2
  logic signed [TQ_W-1:0]   tq_r, tq_nxt;
  logic signed [IN_W-1:0]   f2_r;
  logic                     run2_r;
  // stage 3
  logic signed [ARM_W-1:0]  armp_r, armn_r, fs;
  logic                     run3_r;
  // stage 4
  logic                     sgnp_r, sgnn_r;
  logic [CNT_W-1:0]         cntp_r, cntn_r, cntp_nxt, cntn_nxt;
  logic                     run4_r;
  // stage 5
  logic [PWM_W-1:0]         pos_up_r, pos_down_r, neg_up_r, neg_down_r;
  logic [PWM_W-1:0]         act_p, act_n, idle;

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      px_r   <= $signed({1'b0, coef_tx}) * tx;
      py_r   <= $signed({1'b0, coef_ty}) * ty;
      pz_r   <= $signed({1'b0, coef_tz}) * tz;
      f1_r   <= axis_force;
      run1_r <= run;
    end
  end

  always_comb begin
    tq_nxt = '0;
    tq_nxt = neg[0] ? tq_nxt - TQ_W'(px_r) : tq_nxt + TQ_W'(px_r);
    tq_nxt = neg[1] ? tq_nxt - TQ_W'(py_r) : tq_nxt + TQ_W'(py_r);
    tq_nxt = neg[2] ? tq_nxt - TQ_W'(pz_r) : tq_nxt + TQ_W'(pz_r);
  end

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      tq_r   <= tq_nxt;
      f2_r   <= f1_r;
      run2_r <= run1_r;
    end
  end

  assign fs = ARM_W'(f2_r) <<< COEF_FRAC;

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      armp_r <= fs + ARM_W'(tq_r);
      armn_r <= fs - ARM_W'(tq_r);
      run3_r <= run2_r;
    end
  end

  // magnitude truncated toward zero to whole counts
  always_comb begin
    logic [MAG_W-1:0] magp, magn;
    magp     = armp_r[ARM_W-1] ? MAG_W'(-armp_r) : MAG_W'(armp_r);
    magn     = armn_r[ARM_W-1] ? MAG_W'(-armn_r) : MAG_W'(armn_r);
    cntp_nxt = CNT_W'(magp >> SHIFT);
    cntn_nxt = CNT_W'(magn >> SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv.ld4) begin
      sgnp_r <= armp_r[ARM_W-1];
      sgnn_r <= armn_r[ARM_W-1];
      cntp_r <= cntp_nxt;
      cntn_r <= cntn_nxt;
      run4_r <= run3_r;
    end
  end

  assign idle  = sat_pwm(SUM_W'(idle_cnt));
  assign act_p = sat_pwm(SUM_W'(cntp_r) + SUM_W'(idle_cnt));
  assign act_n = sat_pwm(SUM_W'(cntn_r) + SUM_W'(idle_cnt));

  always_ff @(posedge clk) begin
    if (adv.ld5) begin
      if (!run4_r) begin
        pos_up_r   <= '0;
        pos_down_r <= '0;
        neg_up_r   <= '0;
        neg_down_r <= '0;
      end else begin
        pos_up_r   <= sgnp_r ? idle  : act_p;
        pos_down_r <= sgnp_r ? act_p : idle;
        neg_up_r   <= sgnn_r ? idle  : act_n;
        neg_down_r <= sgnn_r ? act_n : idle;
      end
    end
  end

  assign pos_up   = pos_up_r;
  assign pos_down = pos_down_r;
  assign neg_up   = neg_up_r;
  assign neg_down = neg_down_r;

endmodule

/* hdl/six_arm_bidirectional_thrust_mixer.sv */
// Top level of the six-arm bidirectional thrust mixer: config, pipeline control, arm pairs.
//
//   channel   | dir | handshake          | transaction
//   ----------+-----+--------------------+------------------------------------------
//   in_cmd    | in  | valid/ready        | three forces, three torques, run flag
//   out_pwm   | out | valid/ready        | up and down PWM counts for six arms
//   cfg_*     | in  | write enable only  | one register write (index, data)
//
// Pipeline: five register stages; an accepted transaction passes stages 1 to 5 in order
//   and out_pwm.valid rises as it reaches stage 5; one transaction per cycle while out_pwm.ready.
// Reset: rst_n synchronous, active low; clears stage valids and restores the registers.
// Stalls: each stage loads when empty or when the stage after it moves, so bubbles
//   close up; a held result blocks a stage only once every stage after it is full.
module six_arm_bidirectional_thrust_mixer
  import satm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  satm_cmd_if.sink             in_cmd,
  satm_pwm_if.source           out_pwm
);

  // configuration registers
  logic [MIN_W-1:0]  idle_cnt_r;
  logic [COEF_W-1:0] coef_small_r, coef_mid_r, coef_large_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_cnt_r   <= IDLE_CNT_RST;
      coef_small_r <= COEF_SMALL_RST;
      coef_mid_r   <= COEF_MID_RST;
      coef_large_r <= COEF_LARGE_RST;
    end else if (cfg_wr_en) begin
      unique case (satm_reg_t'(cfg_index))
        REG_IDLE_CNT:   idle_cnt_r   <= MIN_W'(cfg_wdata);
        REG_COEF_SMALL: coef_small_r <= COEF_W'(cfg_wdata);
        REG_COEF_MID:   coef_mid_r   <= COEF_W'(cfg_wdata);
        REG_COEF_LARGE: coef_large_r <= COEF_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // stage valids; bit 0 is stage 1, bit 4 the output stage
  logic [4:0] vld_r, vld_nxt;
  satm_adv_t  adv;

  // load chain runs back from the output: a stage loads when empty or draining
  assign adv.ld5 = !vld_r[4] || out_pwm.ready;
  assign adv.ld4 = !vld_r[3] || adv.ld5;
  assign adv.ld3 = !vld_r[2] || adv.ld4;
  assign adv.ld2 = !vld_r[1] || adv.ld3;
  assign adv.ld1 = !vld_r[0] || adv.ld2;

  assign in_cmd.ready  = adv.ld1;
  assign out_pwm.valid = vld_r[4];

  always_comb begin
    vld_nxt    = vld_r;
    if (adv.ld1) vld_nxt[0] = in_cmd.valid;
    if (adv.ld2) vld_nxt[1] = vld_r[0];
    if (adv.ld3) vld_nxt[2] = vld_r[1];
    if (adv.ld4) vld_nxt[3] = vld_r[2];
    if (adv.ld5) vld_nxt[4] = vld_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Arms 1/2 on z: tq = -m*tx - L*ty + s*tz
  satm_pair u_pair_z (
    .clk        (clk),
    .adv        (adv),
    .coef_tx    (coef_mid_r),
    .coef_ty    (coef_large_r),
    .coef_tz    (coef_small_r),
    .neg        (3'b011),
    .idle_cnt   (idle_cnt_r),
    .axis_force (in_cmd.force_z),
    .tx         (in_cmd.torque_x),
    .ty         (in_cmd.torque_y),
    .tz         (in_cmd.torque_z),
    .run        (in_cmd.run_enable),
    .pos_up     (out_pwm.arm1_up_pwm),
    .pos_down   (out_pwm.arm1_down_pwm),
    .neg_up     (out_pwm.arm2_up_pwm),
    .neg_down   (out_pwm.arm2_down_pwm)
  );

  // Arms 3/4 on x: tq = -s*tx - m*ty - L*tz
  satm_pair u_pair_x (
    .clk        (clk),
    .adv        (adv),
    .coef_tx    (coef_small_r),
    .coef_ty    (coef_mid_r),
    .coef_tz    (coef_large_r),
    .neg        (3'b111),
    .idle_cnt   (idle_cnt_r),
    .axis_force (in_cmd.force_x),
    .tx         (in_cmd.torque_x),
    .ty         (in_cmd.torque_y),
    .tz         (in_cmd.torque_z),
    .run        (in_cmd.run_enable),
    .pos_up     (out_pwm.arm3_up_pwm),
    .pos_down   (out_pwm.arm3_down_pwm),
    .neg_up     (out_pwm.arm4_up_pwm),
    .neg_down   (out_pwm.arm4_down_pwm)
  );

  // Arms 5/6 on y: tq = -L*tx + s*ty + m*tz
  satm_pair u_pair_y (
    .clk        (clk),
    .adv        (adv),
    .coef_tx    (coef_large_r),
    .coef_ty    (coef_small_r),
    .coef_tz    (coef_mid_r),
    .neg        (3'b001),
    .idle_cnt   (idle_cnt_r),
    .axis_force (in_cmd.force_y),
    .tx         (in_cmd.torque_x),
    .ty         (in_cmd.torque_y),
    .tz         (in_cmd.torque_z),
    .run        (in_cmd.run_enable),
    .pos_up     (out_pwm.arm5_up_pwm),
    .pos_down   (out_pwm.arm5_down_pwm),
    .neg_up     (out_pwm.arm6_up_pwm),
    .neg_down   (out_pwm.arm6_down_pwm)
  );

  // idle count as a motor sees it, for the checks below
  logic [PWM_W-1:0] idle_pwm;
  assign idle_pwm = sat_pwm(SUM_W'(idle_cnt_r));

`ifndef NO_ASSERTIONS
  // a draining or empty output stage frees the whole pipe
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pwm.ready || !out_pwm.valid) |-> in_cmd.ready)
    else $error("input stalled although output stage can move");

  // an accepted transaction always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cmd.valid && in_cmd.ready) |=> vld_r[0])
    else $error("accepted transaction lost at stage 1");

  // one motor of arms 1 and 4 idles, or both are off when stopped
  a_idle_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_pwm.valid |->
      (out_pwm.arm1_up_pwm == idle_pwm || out_pwm.arm1_down_pwm == idle_pwm ||
       (out_pwm.arm1_up_pwm == '0 && out_pwm.arm1_down_pwm == '0)) &&
      (out_pwm.arm4_up_pwm == idle_pwm || out_pwm.arm4_down_pwm == idle_pwm ||
       (out_pwm.arm4_up_pwm == '0 && out_pwm.arm4_down_pwm == '0)))
    else $error("neither motor of an arm at idle thrust");
`endif

endmodule
